[design/kss_pkg.sv]
// kss_pkg: operation codes, status codes, fsm states and the cell control
// struct shared by the keyed set store modules
// no dependencies
package kss_pkg;

   localparam int KEY_BITS       = 32;
   localparam int COUNT_OUT_BITS = 5;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_GET    = 2'd2,
      KIND_POP    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_DUP     = 3'd1,
      ST_MISSING = 3'd2,
      ST_EMPTY   = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic cmp_en;    // capture select flag against the key bus
      logic is_pop;    // select the last occupied cell instead of a key match
      logic write_en;  // append key bus and handle into the cell at the count
      logic shift_en;  // close the gap after the selected cell
   } cell_ctl_type;

endpackage

[design/kss_cell.sv]
// kss_cell: one slot of the store, holding a key and a handle, with its
// own compare and a link to the next slot for gap closing
// depends on kss_pkg
module kss_cell #(
   parameter int IDX         = 0,
   parameter int HANDLE_BITS = 8,
   parameter int COUNT_BITS  = 5
) (
   input  logic                     clock,
   input  kss_pkg::cell_ctl_type    ctl,
   input  logic [31:0]              key_bus,
   input  logic [HANDLE_BITS-1:0]   handle_bus,
   input  logic [COUNT_BITS-1:0]    count,
   input  logic [31:0]              nb_key,
   input  logic [HANDLE_BITS-1:0]   nb_handle,
   input  logic                     past_in,
   output logic [31:0]              key,
   output logic [HANDLE_BITS-1:0]   handle,
   output logic                     sel,
   output logic                     past_out
);
   import kss_pkg::*;

   logic [31:0]            key_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic                   sel_ff;
   logic                   occupied;
   logic                   is_last;
   logic                   is_tail;

   assign occupied = COUNT_BITS'(IDX) < count;
   assign is_last  = COUNT_BITS'(IDX + 1) == count;
   assign is_tail  = COUNT_BITS'(IDX) == count;

   always_ff @(posedge clock) begin
      if (ctl.cmp_en) begin
         sel_ff <= ctl.is_pop ? is_last : (occupied && key_ff == key_bus);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.write_en && is_tail) begin
         key_ff    <= key_bus;
         handle_ff <= handle_bus;
      end else if (ctl.shift_en && (past_in || sel_ff)) begin
         key_ff    <= nb_key;
         handle_ff <= nb_handle;
      end
   end

   assign key      = key_ff;
   assign handle   = handle_ff;
   assign sel      = sel_ff;
   assign past_out = past_in | sel_ff;

endmodule

[design/keyed_set_store.sv]
// keyed_set_store: order-preserving keyed set built as a row of cells
// the cells capture their compare at the req transfer edge; the execute edge in
//   S_EXEC then updates the row and loads the output register and rsp_valid
// req_ready is high only in S_IDLE, so a new item is taken only after the last
//   one has executed; the execute edge waits while an unaccepted response still
//   holds the output register
// reset clears the fill count, the sequencer and rsp_valid and holds req_ready low;
//   cell contents are undefined until written and only cells below the count are read
module keyed_set_store #(
   parameter int CAPACITY    = 16,
   parameter int HANDLE_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_kind,
   input  logic signed [31:0]      req_key,
   input  logic [HANDLE_BITS-1:0]  req_handle_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_found,
   output logic [HANDLE_BITS-1:0]  rsp_handle_out,
   output logic signed [31:0]      rsp_key_out,
   output logic [2:0]              rsp_status,
   output logic [4:0]              rsp_count
);
   import kss_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   // sequencer and operation registers
   state_type              state_ff, state_in;
   kind_type               op_kind_ff;
   logic [31:0]            op_key_ff;
   logic [HANDLE_BITS-1:0] op_handle_ff;
   logic [CW-1:0]          count_ff, count_in;

   // output register
   logic                   rsp_valid_ff;
   logic                   rsp_found_ff, rsp_found_in;
   logic [HANDLE_BITS-1:0] rsp_handle_ff, rsp_handle_in;
   logic [31:0]            rsp_key_ff, rsp_key_in;
   status_type             rsp_status_ff, rsp_status_in;

   // cell row
   cell_ctl_type           ctl;
   logic [31:0]            key_bus;
   logic [31:0]            cell_key [CAPACITY];
   logic [HANDLE_BITS-1:0] cell_handle [CAPACITY];
   logic [CAPACITY-1:0]    sel_vec;
   logic [CAPACITY:0]      past_chain;

   logic                   accept;
   logic                   go;
   logic                   any_sel;
   logic                   full;
   logic                   add_ok;
   logic                   take_out;
   logic [31:0]            hit_key;
   logic [HANDLE_BITS-1:0] hit_handle;

   assign accept = req_valid && req_ready;
   // the execute cycle completes only when the output register is free or being read out
   assign go     = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign full   = count_ff == CW'(CAPACITY);

   // ---------------------------------------------------------------
   // row of cells; each passes its data and a past-the-hit flag down
   // ---------------------------------------------------------------
   assign past_chain[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [31:0]            nb_key;
      logic [HANDLE_BITS-1:0] nb_handle;

      if (i == CAPACITY - 1) begin : g_end
         // the last cell has no neighbor, it keeps its own data
         assign nb_key    = cell_key[i];
         assign nb_handle = cell_handle[i];
      end else begin : g_mid
         assign nb_key    = cell_key[i+1];
         assign nb_handle = cell_handle[i+1];
      end

      kss_cell #(
         .IDX         (i),
         .HANDLE_BITS (HANDLE_BITS),
         .COUNT_BITS  (CW)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .key_bus    (key_bus),
         .handle_bus (op_handle_ff),
         .count      (count_ff),
         .nb_key     (nb_key),
         .nb_handle  (nb_handle),
         .past_in    (past_chain[i]),
         .key        (cell_key[i]),
         .handle     (cell_handle[i]),
         .sel        (sel_vec[i]),
         .past_out   (past_chain[i+1])
      );
   end

   // selected entry readout; at most one cell is selected
   always_comb begin
      hit_key    = '0;
      hit_handle = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_key    = hit_key    | (sel_vec[i] ? cell_key[i]    : '0);
         hit_handle = hit_handle | (sel_vec[i] ? cell_handle[i] : '0);
      end
   end

   assign any_sel = |sel_vec;

   // ---------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (go) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // execute: result fields and row update
   // ---------------------------------------------------------------
   always_comb begin
      rsp_found_in  = 1'b0;
      rsp_handle_in = '0;
      rsp_key_in    = '0;
      rsp_status_in = ST_OK;
      count_in      = count_ff;
      add_ok        = 1'b0;
      take_out      = 1'b0;
      case (op_kind_ff)
         KIND_ADD: begin
            if (any_sel) begin
               rsp_found_in  = 1'b1;
               rsp_status_in = ST_DUP;
            end else if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               add_ok   = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         KIND_REMOVE, KIND_GET: begin
            if (any_sel) begin
               rsp_found_in  = 1'b1;
               rsp_handle_in = hit_handle;
               rsp_key_in    = hit_key;
               if (op_kind_ff == KIND_REMOVE) begin
                  take_out = 1'b1;
                  count_in = count_ff - CW'(1);
               end
            end else begin
               rsp_status_in = ST_MISSING;
            end
         end
         KIND_POP: begin
            if (count_ff == '0) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_found_in  = 1'b1;
               rsp_handle_in = hit_handle;
               rsp_key_in    = hit_key;
               count_in      = count_ff - CW'(1);
            end
         end
         default: rsp_status_in = ST_OK;
      endcase
   end

   // ---------------------------------------------------------------
   // sequencer outputs: handshake, key bus and cell control
   // ---------------------------------------------------------------
   always_comb begin
      req_ready    = 1'b0;
      key_bus      = op_key_ff;
      ctl          = '0;
      case (state_ff)
         S_IDLE: begin
            // cells compare against the incoming key at the transfer edge
            req_ready  = !reset;
            key_bus    = req_key;
            ctl.cmp_en = accept;
            ctl.is_pop = req_kind == KIND_POP;
         end
         S_EXEC: begin
            ctl.write_en = go && add_ok;
            ctl.shift_en = go && take_out;
         end
         default: req_ready = 1'b0;
      endcase
   end

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (go) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_kind_ff   <= kind_type'(req_kind);
         op_key_ff    <= req_key;
         op_handle_ff <= req_handle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_found_ff  <= rsp_found_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // rsp_count follows the fill count of the last completed item
   logic [CW-1:0] rsp_count_ff;

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_key_out    = rsp_key_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = COUNT_OUT_BITS'(rsp_count_ff);

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // keys are unique among occupied cells, so at most one cell is selected
   a_sel_onehot : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |-> $onehot0(sel_vec))
      else $error("more than one cell selected");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("fill count beyond capacity");

   // a dropped add only happens on a full store
   a_full_count : assert property (@(posedge clock) disable iff (reset)
      go && rsp_status_in == ST_FULL |=> rsp_count_ff == CW'(CAPACITY))
      else $error("full status with store not full");

   // pop of a nonempty store always finds its last cell
   a_pop_hit : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC && op_kind_ff == KIND_POP && count_ff != '0 |-> any_sel)
      else $error("pop found no last cell");

endmodule

[tb/tb_keyed_set_store.sv]
// tb_keyed_set_store: self-checking testbench for the keyed set store
// drives add, remove, get and pop transfers against a behavioral copy of the store
// depends on kss_pkg and keyed_set_store
module tb_keyed_set_store;
   timeunit 1ns;
   timeprecision 1ps;

   import kss_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int HANDLE_BITS = 8;
   localparam int RANDOM_OPS  = 1025;
   localparam int POOL_SIZE   = 24;
   localparam int HOLD_AT     = 500;    // random item index that starts the long hold-off
   localparam int HOLD_CYCLES = 120;
   localparam int REPORT_MAX  = 10;

   // one response as the store reports it
   typedef struct packed {
      logic                   found;
      logic [HANDLE_BITS-1:0] handle;
      logic signed [31:0]     key;
      status_type             status;
      logic [4:0]             count;
   } set_result_type;

   // one line of the directed table; reps walks key and handle upward
   typedef struct {
      kind_type               kind;
      logic signed [31:0]     key;
      logic [HANDLE_BITS-1:0] handle;
      int                     reps;
      bit                     typed;
      set_result_type         want;
   } op_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_kind = 2'd0;
   logic signed [31:0]     req_key = 32'sd0;
   logic [HANDLE_BITS-1:0] req_handle_in = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_found;
   logic [HANDLE_BITS-1:0] rsp_handle_out;
   logic signed [31:0]     rsp_key_out;
   logic [2:0]             rsp_status;
   logic [4:0]             rsp_count;

   // behavioral copy of the store contents
   logic signed [31:0]     shadow_keys [CAPACITY];
   logic [HANDLE_BITS-1:0] shadow_handles [CAPACITY];
   int                     shadow_count = 0;

   set_result_type pending_results[$];
   op_row_type     op_table[$];

   int fault_count = 0;
   int report_count = 0;

   // sender pacing and the handshake with the receiver for the long hold-off
   int burst_left = 0;
   bit hold_request = 1'b0;
   bit holding_off = 1'b0;

   keyed_set_store #(
      .CAPACITY    (CAPACITY),
      .HANDLE_BITS (HANDLE_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_key        (req_key),
      .req_handle_in  (req_handle_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_handle_out (rsp_handle_out),
      .rsp_key_out    (rsp_key_out),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic set_result_type make_result(input logic found,
                                                  input logic [HANDLE_BITS-1:0] handle,
                                                  input logic signed [31:0] key,
                                                  input status_type status,
                                                  input logic [4:0] count);
      set_result_type r;
      r.found  = found;
      r.handle = handle;
      r.key    = key;
      r.status = status;
      r.count  = count;
      return r;
   endfunction

   // applies one operation to the shadow store and returns what the store must answer
   function automatic set_result_type apply_set_op(input kind_type kind,
                                                   input logic signed [31:0] key,
                                                   input logic [HANDLE_BITS-1:0] handle);
      set_result_type r;
      int             hit;
      r = make_result(1'b0, '0, 32'sd0, ST_OK, 5'd0);
      // lowest matching position wins
      hit = -1;
      for (int i = 0; i < shadow_count; i++) begin
         if (hit < 0 && shadow_keys[i] == key) hit = i;
      end
      case (kind)
         KIND_ADD: begin
            // duplicate check comes before the full check
            if (hit >= 0) begin
               r.found  = 1'b1;
               r.status = ST_DUP;
            end else if (shadow_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               shadow_keys[shadow_count]    = key;
               shadow_handles[shadow_count] = handle;
               shadow_count++;
            end
         end
         KIND_REMOVE, KIND_GET: begin
            if (hit < 0) begin
               r.status = ST_MISSING;
            end else begin
               r.found  = 1'b1;
               r.handle = shadow_handles[hit];
               r.key    = shadow_keys[hit];
               if (kind == KIND_REMOVE) begin
                  // close the gap, order kept
                  for (int i = hit; i + 1 < shadow_count; i++) begin
                     shadow_keys[i]    = shadow_keys[i + 1];
                     shadow_handles[i] = shadow_handles[i + 1];
                  end
                  shadow_count--;
               end
            end
         end
         default: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               shadow_count--;
               r.found  = 1'b1;
               r.handle = shadow_handles[shadow_count];
               r.key    = shadow_keys[shadow_count];
            end
         end
      endcase
      r.count = shadow_count[4:0];
      return r;
   endfunction

   task automatic add_row(input kind_type kind, input logic signed [31:0] key,
                          input logic [HANDLE_BITS-1:0] handle, input int reps,
                          input bit typed, input set_result_type want);
      op_row_type row;
      row.kind   = kind;
      row.key    = key;
      row.handle = handle;
      row.reps   = reps;
      row.typed  = typed;
      row.want   = want;
      op_table.push_back(row);
   endtask

   // offers one transfer, called right after a rising edge; returns right after
   // the edge that took it, then maybe opens a gap before the next burst
   task automatic offer_op(input kind_type kind, input logic signed [31:0] key,
                           input logic [HANDLE_BITS-1:0] handle, input bit typed,
                           input set_result_type want);
      set_result_type predicted;
      int             gap;
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_key       <= key;
      req_handle_in <= handle;
      do @(posedge clock); while (!req_ready);
      // transfer taken at this edge: the shadow store moves on in step
      predicted = apply_set_op(kind, key, handle);
      pending_results.push_back(typed ? want : predicted);
      if (burst_left > 0) burst_left--;
      // keep offering while the receiver holds off so the block backs up
      if (burst_left == 0 && !holding_off) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // stimulus: directed table first, then random traffic
   initial begin
      logic signed [31:0]     key_pool [POOL_SIZE];
      logic signed [31:0]     key;
      logic [HANDLE_BITS-1:0] handle;
      kind_type               kind;
      set_result_type         none;
      bit                     filling;
      int                     pick;
      int                     choice;

      none = make_result(1'b0, '0, 32'sd0, ST_OK, 5'd0);

      // empty store: pop and lookup both miss
      add_row(KIND_POP, 32'sh1234_5678, 8'h00, 1, 1'b1,
              make_result(1'b0, 8'h00, 32'sd0, ST_EMPTY, 5'd0));
      add_row(KIND_GET, 32'sd0, 8'h00, 1, 1'b1,
              make_result(1'b0, 8'h00, 32'sd0, ST_MISSING, 5'd0));
      // key extremes with handle extremes
      add_row(KIND_ADD, 32'sh8000_0000, 8'hff, 1, 1'b1,
              make_result(1'b0, 8'h00, 32'sd0, ST_OK, 5'd1));
      add_row(KIND_ADD, 32'sh7fff_ffff, 8'h00, 1, 1'b1,
              make_result(1'b0, 8'h00, 32'sd0, ST_OK, 5'd2));
      // duplicate add leaves the store alone
      add_row(KIND_ADD, 32'sh8000_0000, 8'h55, 1, 1'b1,
              make_result(1'b1, 8'h00, 32'sd0, ST_DUP, 5'd2));
      // fill to capacity with keys -7 .. 6, crossing -1 and 0
      add_row(KIND_ADD, -32'sd7, 8'h80, 14, 1'b0, none);
      // full store drops a new key, but a duplicate still reports duplicate
      add_row(KIND_ADD, 32'sd1234, 8'h3c, 1, 1'b1,
              make_result(1'b0, 8'h00, 32'sd0, ST_FULL, 5'd16));
      add_row(KIND_ADD, 32'sd0, 8'h11, 1, 1'b1,
              make_result(1'b1, 8'h00, 32'sd0, ST_DUP, 5'd16));
      add_row(KIND_GET, 32'sh7fff_ffff, 8'h00, 1, 1'b1,
              make_result(1'b1, 8'h00, 32'sh7fff_ffff, ST_OK, 5'd16));
      // remove from the middle shifts the tail down, then pop the new tail
      add_row(KIND_REMOVE, -32'sd7, 8'h00, 1, 1'b0, none);
      add_row(KIND_POP, 32'sd0, 8'h00, 1, 1'b0, none);
      add_row(KIND_REMOVE, 32'sd99, 8'h00, 1, 1'b1,
              make_result(1'b0, 8'h00, 32'sd0, ST_MISSING, 5'd14));
      // remove at the head
      add_row(KIND_REMOVE, 32'sh8000_0000, 8'h00, 1, 1'b0, none);

      key_pool[0] = 32'sh8000_0000;
      key_pool[1] = 32'sh7fff_ffff;
      key_pool[2] = 32'sd0;
      key_pool[3] = -32'sd1;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (op_table[r]) begin
         for (int j = 0; j < op_table[r].reps; j++) begin
            offer_op(op_table[r].kind, op_table[r].key + j,
                     op_table[r].handle + j[HANDLE_BITS-1:0],
                     op_table[r].typed, op_table[r].want);
         end
      end

      // random traffic swings between filling and draining so both the full
      // and the empty store come up again and again
      filling = 1'b1;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 48 == 0) filling = !filling;
         if (n == HOLD_AT) hold_request = 1'b1;
         choice = $urandom_range(0, 99);
         if (filling) begin
            kind = (choice < 60) ? KIND_ADD : (choice < 75) ? KIND_REMOVE :
                   (choice < 90) ? KIND_GET : KIND_POP;
         end else begin
            kind = (choice < 25) ? KIND_ADD : (choice < 55) ? KIND_REMOVE :
                   (choice < 75) ? KIND_GET : KIND_POP;
         end
         // lookups mostly hit a stored key; adds mix pool keys (duplicates) and fresh ones
         pick = $urandom_range(0, 9);
         if (kind != KIND_ADD && shadow_count > 0 && pick < 6)
            key = shadow_keys[$urandom_range(0, shadow_count - 1)];
         else if (pick < 8)
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else
            key = $urandom;
         handle = HANDLE_BITS'($urandom_range(0, (1 << HANDLE_BITS) - 1));
         offer_op(kind, key, handle, 1'b0, none);
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // let any stray response show up
      repeat (20) @(posedge clock);
      if (fault_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // receiver: stretches of always ready, random stalls, mostly stalled and
   // toggling, plus one long hold-off while the sender keeps pushing
   initial begin
      int  mode;
      int  span;
      logic next_ready;
      do @(posedge clock); while (reset);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 80);
         for (int c = 0; c < span; c++) begin
            if (hold_request) begin
               hold_request = 1'b0;
               holding_off = 1'b1;
               for (int h = 0; h < HOLD_CYCLES; h++) begin
                  rsp_ready <= 1'b0;
                  @(posedge clock);
               end
               holding_off = 1'b0;
            end
            case (mode)
               0:       next_ready = 1'b1;
               1:       next_ready = 1'($urandom_range(0, 1));
               2:       next_ready = ($urandom_range(0, 3) == 0);
               default: next_ready = !rsp_ready;
            endcase
            rsp_ready <= next_ready;
            @(posedge clock);
         end
      end
   end

   // response checker: every rsp transfer is matched against the oldest expectation
   always @(posedge clock) begin
      set_result_type seen;
      set_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.found  = rsp_found;
         seen.handle = rsp_handle_out;
         seen.key    = rsp_key_out;
         seen.status = status_type'(rsp_status);
         seen.count  = rsp_count;
         if (pending_results.size() == 0) begin
            fault_count++;
            if (report_count < REPORT_MAX) begin
               report_count++;
               $display("%0t: response with nothing expected: found %0b handle %0h key %0d status %0d count %0d",
                        $realtime, seen.found, seen.handle, seen.key, seen.status, seen.count);
            end
         end else begin
            want = pending_results.pop_front();
            if (seen !== want) begin
               fault_count++;
               if (report_count < REPORT_MAX) begin
                  report_count++;
                  $display("%0t: mismatch: expected found %0b handle %0h key %0d status %0d count %0d",
                           $realtime, want.found, want.handle, want.key, want.status, want.count);
                  $display("%0t:           actual   found %0b handle %0h key %0d status %0d count %0d",
                           $realtime, seen.found, seen.handle, seen.key, seen.status, seen.count);
               end
            end
         end
      end
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
